>>> rtl/binary_to_decimal_digits_core_macros.svh
// ----------------------------------------------------------------------------
// Binary to decimal digits assertion macros
// Concurrent assertion helpers shared by the conversion core.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_DIGITS_CORE_MACROS_SVH
`define BINARY_TO_DECIMAL_DIGITS_CORE_MACROS_SVH

`ifndef SYNTH
`define BTDD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("btdd assertion failed");
`define BTDD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("btdd assertion failed");
`else
`define BTDD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BTDD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/btdd_pkg.sv
// ----------------------------------------------------------------------------
// Binary to decimal digits package
// Shared widths, codes and the control word of the digit cells.
// ----------------------------------------------------------------------------
package btdd_pkg;

    localparam int MAX_DIGITS = 20;
    localparam int DIGIT_W    = 4;
    localparam int VALUE_W    = 64;
    localparam int CMD_W      = 2;
    localparam int CHAR_W     = 6;
    localparam int CNT_W      = $clog2(VALUE_W + 1);
    localparam int REMAIN_W   = $clog2(MAX_DIGITS + 1);

    localparam logic [CMD_W-1:0] CMD_S8  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_S16 = 2'd1;
    localparam logic [CMD_W-1:0] CMD_S64 = 2'd2;
    localparam logic [CMD_W-1:0] CMD_U64 = 2'd3;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
    localparam logic [CHAR_W-1:0] ASCII_NINE = 6'd57;

    typedef struct packed {
        logic clear;
        logic dabble;
        logic shift;
    } t_cell_ctrl;

endpackage

>>> rtl/btdd_cell.sv
// ----------------------------------------------------------------------------
// Binary to decimal digits cell
// One decimal digit of the conversion chain: add-three correction and shift
// during conversion, and a digit shift toward the top of the chain for output.
// ----------------------------------------------------------------------------
module btdd_cell (
    input  logic                           i_clk,
    input  btdd_pkg::t_cell_ctrl           i_ctrl,
    input  logic                           i_carry,
    input  logic [btdd_pkg::DIGIT_W-1:0]   i_digit,
    output logic                           o_carry,
    output logic [btdd_pkg::DIGIT_W-1:0]   o_digit
);
    import btdd_pkg::*;

    logic [DIGIT_W-1:0] r_digit;
    logic [DIGIT_W-1:0] n_digit;
    logic [DIGIT_W-1:0] w_adj;

    always_comb begin
        w_adj = (r_digit >= 4'd5) ? r_digit + 4'd3 : r_digit;
        if (i_ctrl.clear) begin
            n_digit = '0;
        end else if (i_ctrl.dabble) begin
            n_digit = {w_adj[DIGIT_W-2:0], i_carry};
        end else if (i_ctrl.shift) begin
            n_digit = i_digit;
        end else begin
            n_digit = r_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    assign o_carry = w_adj[DIGIT_W-1];
    assign o_digit = r_digit;

endmodule

>>> rtl/binary_to_decimal_digits_core.sv
// ----------------------------------------------------------------------------
// Binary to decimal digits core
// Converts an 8, 16 or 64-bit value to the ASCII decimal digits of its
// magnitude, most significant first, one digit per output transaction.
//
//   Channel  Direction  Handshake           Payload
//   input    in         i_valid / o_stall   i_command, i_value
//   output   out        o_valid / i_stall   o_digit, o_last
//
// After the accepting cycle clears the digit cells, an item runs B
// shift-add-3 steps through the digit cells, where B is 8, 16 or 64 for
// the width mode, then the chain shifts out one digit position at a time.
// Leading zero positions are dropped at one per cycle.
// Reset is synchronous and active low; it clears the control state only.
// An output stall holds the chain until the digit register drains.
// ----------------------------------------------------------------------------
`include "binary_to_decimal_digits_core_macros.svh"

module binary_to_decimal_digits_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [btdd_pkg::CMD_W-1:0]     i_command,
    input  logic [btdd_pkg::VALUE_W-1:0]   i_value,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [btdd_pkg::CHAR_W-1:0]    o_digit,
    output logic                           o_last
);
    import btdd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic [VALUE_W-1:0]    r_bin;
    logic [VALUE_W-1:0]    n_bin;
    logic [CNT_W-1:0]      r_bit_cnt;
    logic [CNT_W-1:0]      n_bit_cnt;
    logic [REMAIN_W-1:0]   r_remain;
    logic [REMAIN_W-1:0]   n_remain;
    logic                  r_seen;
    logic                  n_seen;
    logic                  r_o_valid;
    logic                  n_o_valid;
    logic [CHAR_W-1:0]     r_o_digit;
    logic [CHAR_W-1:0]     n_o_digit;
    logic                  r_o_last;
    logic                  n_o_last;

    logic                  w_accept;
    logic                  w_out_free;
    logic [7:0]            w_mag8;
    logic [15:0]           w_mag16;
    logic [VALUE_W-1:0]    w_mag64;
    logic [DIGIT_W-1:0]    w_top;
    t_cell_ctrl            w_ctrl;

    logic [DIGIT_W-1:0]    w_digit [MAX_DIGITS];
    logic                  w_carry [MAX_DIGITS];

    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_o_valid || !i_stall;
    assign w_top      = w_digit[MAX_DIGITS-1];

    assign w_mag8  = i_value[7]  ? 8'(-i_value[7:0])   : i_value[7:0];
    assign w_mag16 = i_value[15] ? 16'(-i_value[15:0]) : i_value[15:0];
    assign w_mag64 = (i_command == CMD_S64 && i_value[VALUE_W-1]) ? -i_value : i_value;

    genvar g;
    generate
        for (g = 0; g < MAX_DIGITS; g++) begin : g_cell
            logic                w_cin;
            logic [DIGIT_W-1:0]  w_din;

            if (g == 0) begin : g_first
                assign w_cin = r_bin[VALUE_W-1];
                assign w_din = '0;
            end else begin : g_rest
                assign w_cin = w_carry[g-1];
                assign w_din = w_digit[g-1];
            end

            btdd_cell u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_ctrl),
                .i_carry (w_cin),
                .i_digit (w_din),
                .o_carry (w_carry[g]),
                .o_digit (w_digit[g])
            );
        end
    endgenerate

    always_comb begin
        n_state   = r_state;
        n_bin     = r_bin;
        n_bit_cnt = r_bit_cnt;
        n_remain  = r_remain;
        n_seen    = r_seen;
        n_o_valid = r_o_valid && i_stall;
        n_o_digit = r_o_digit;
        n_o_last  = r_o_last;
        w_ctrl    = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_ctrl.clear = 1'b1;
                    n_state      = S_CONV;
                    case (i_command)
                        CMD_S8: begin
                            n_bin     = {w_mag8, (VALUE_W-8)'(0)};
                            n_bit_cnt = CNT_W'(8);
                        end
                        CMD_S16: begin
                            n_bin     = {w_mag16, (VALUE_W-16)'(0)};
                            n_bit_cnt = CNT_W'(16);
                        end
                        default: begin
                            n_bin     = w_mag64;
                            n_bit_cnt = CNT_W'(VALUE_W);
                        end
                    endcase
                end
            end
            S_CONV: begin
                w_ctrl.dabble = 1'b1;
                n_bin         = {r_bin[VALUE_W-2:0], 1'b0};
                n_bit_cnt     = r_bit_cnt - 1'b1;
                if (r_bit_cnt == CNT_W'(1)) begin
                    n_state  = S_EMIT;
                    n_remain = REMAIN_W'(MAX_DIGITS);
                    n_seen   = 1'b0;
                end
            end
            S_EMIT: begin
                if (!r_seen && w_top == '0 && r_remain != REMAIN_W'(1)) begin
                    w_ctrl.shift = 1'b1;
                    n_remain     = r_remain - 1'b1;
                end else if (w_out_free) begin
                    w_ctrl.shift = 1'b1;
                    n_remain     = r_remain - 1'b1;
                    n_seen       = 1'b1;
                    n_o_valid    = 1'b1;
                    n_o_digit    = ASCII_ZERO + CHAR_W'(w_top);
                    n_o_last     = (r_remain == REMAIN_W'(1));
                    if (r_remain == REMAIN_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
        r_bin     <= n_bin;
        r_bit_cnt <= n_bit_cnt;
        r_remain  <= n_remain;
        r_seen    <= n_seen;
        r_o_digit <= n_o_digit;
        r_o_last  <= n_o_last;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_o_valid;
    assign o_digit = r_o_digit;
    assign o_last  = r_o_last;

    `BTDD_ASSERT_IMP(a_digit_range, i_clk, i_rst_n, r_o_valid, (r_o_digit >= ASCII_ZERO) && (r_o_digit <= ASCII_NINE))
    `BTDD_ASSERT_IMP(a_emit_remain, i_clk, i_rst_n, r_state == S_EMIT, r_remain != '0)
    `BTDD_ASSERT_NXT(a_accept_load, i_clk, i_rst_n, w_accept, (r_state == S_CONV) && (r_bit_cnt == CNT_W'(8) || r_bit_cnt == CNT_W'(16) || r_bit_cnt == CNT_W'(VALUE_W)))

endmodule

>>> bench/btdd_digit_checker.sv
// ----------------------------------------------------------------------------
// Binary to decimal digits checker
// Watches the input and output channels of the conversion core. For every
// accepted number it computes the expected ASCII digits of its magnitude and
// compares each accepted digit with the oldest expected one.
// ----------------------------------------------------------------------------
module btdd_digit_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [btdd_pkg::CMD_W-1:0]     i_command,
    input  logic [btdd_pkg::VALUE_W-1:0]   i_value,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [btdd_pkg::CHAR_W-1:0]    i_digit,
    input  logic                           i_last,
    output int                             o_errors,
    output int                             o_pending,
    output int                             o_numbers,
    output int                             o_digits
);
    import btdd_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] digit;
        logic              last;
    } t_digit_item;

    t_digit_item digits_due[$];
    int          error_count  = 0;
    int          number_count = 0;
    int          digit_count  = 0;

    assign o_errors  = error_count;
    assign o_pending = digits_due.size();
    assign o_numbers = number_count;
    assign o_digits  = digit_count;

    function automatic void queue_decimal_digits(logic [CMD_W-1:0] cmd,
                                                 logic [VALUE_W-1:0] raw);
        logic [VALUE_W-1:0] mag;
        logic [3:0]         lsd_first [MAX_DIGITS];
        int                 n;
        t_digit_item        item;
        case (cmd)
            CMD_S8: begin
                mag = {56'd0, raw[7:0]};
                if (raw[7]) mag = 64'd256 - mag;
            end
            CMD_S16: begin
                mag = {48'd0, raw[15:0]};
                if (raw[15]) mag = 64'd65536 - mag;
            end
            CMD_S64: begin
                mag = raw[63] ? (~raw + 64'd1) : raw;
            end
            default: begin
                mag = raw;
            end
        endcase
        n = 0;
        do begin
            lsd_first[n] = 4'(mag % 64'd10);
            mag          = mag / 64'd10;
            n++;
        end while (mag != 0 && n < MAX_DIGITS);
        for (int k = n - 1; k >= 0; k--) begin
            item.digit = ASCII_ZERO + CHAR_W'(lsd_first[k]);
            item.last  = (k == 0);
            digits_due.push_back(item);
        end
    endfunction

    always @(posedge i_clk) begin
        t_digit_item want;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                queue_decimal_digits(i_command, i_value);
                number_count++;
            end
            if (i_out_valid && !i_out_stall) begin
                digit_count++;
                if (digits_due.size() == 0) begin
                    $display("%0t: unexpected digit transaction, digit %0d last %0d",
                             $time, i_digit, i_last);
                    error_count++;
                end else begin
                    want = digits_due.pop_front();
                    if (i_digit !== want.digit) begin
                        $display("%0t: digit mismatch, expected %0d, actual %0d",
                                 $time, want.digit, i_digit);
                        error_count++;
                    end
                    if (i_last !== want.last) begin
                        $display("%0t: last mismatch, expected %0d, actual %0d",
                                 $time, want.last, i_last);
                        error_count++;
                    end
                end
            end
        end
    end

endmodule

>>> bench/binary_to_decimal_digits_core_tb.sv
// ----------------------------------------------------------------------------
// Binary to decimal digits core testbench
// Drives directed boundary numbers for every width mode, then random numbers
// under three idle patterns, one long output hold and drain pauses. A
// separate checker predicts the digit stream and counts mismatches.
// ----------------------------------------------------------------------------
module binary_to_decimal_digits_core_tb;
    import btdd_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 200;

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               i_valid   = 1'b0;
    logic               o_stall;
    logic [CMD_W-1:0]   i_command = CMD_S8;
    logic [VALUE_W-1:0] i_value   = '0;
    logic               o_valid;
    logic               i_stall   = 1'b0;
    logic [CHAR_W-1:0]  o_digit;
    logic               o_last;

    int errors;
    int pending;
    int numbers;
    int digits;

    int send_idle_pct    = 26;
    int recv_idle_pct    = 56;
    int holds_requested  = 0;
    int holds_served     = 0;
    int hold_left        = 0;
    int quiet_cycles     = 0;

    binary_to_decimal_digits_core uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_command (i_command),
        .i_value   (i_value),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_digit   (o_digit),
        .o_last    (o_last)
    );

    btdd_digit_checker checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_command   (i_command),
        .i_value     (i_value),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_digit     (o_digit),
        .i_last      (o_last),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_numbers   (numbers),
        .o_digits    (digits)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (holds_served != holds_requested) begin
            i_stall      <= 1'b1;
            hold_left    <= HOLD_CYCLES - 1;
            holds_served <= holds_served + 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_number(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] raw);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= cmd;
        i_value   <= raw;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic wait_for_drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [VALUE_W-1:0] random_number();
        logic [VALUE_W-1:0] full;
        logic [VALUE_W-1:0] pow10;
        full = {$urandom, $urandom};
        case ($urandom_range(5))
            0, 1: return full;
            2: return VALUE_W'($urandom_range(999));
            3: begin
                pow10 = 64'd1;
                repeat ($urandom_range(19)) pow10 = pow10 * 64'd10;
                return pow10 + VALUE_W'($urandom_range(2)) - 64'd1;
            end
            4: return -VALUE_W'($urandom_range(1000));
            default: begin
                case ($urandom_range(3))
                    0: return {full[63:8], 8'h80};
                    1: return {full[63:16], 16'h8000};
                    2: return {full[63:16], 16'h7FFF};
                    default: return {1'b1, full[62:0]};
                endcase
            end
        endcase
    endfunction

    task automatic send_random(int count);
        repeat (count) send_number(CMD_W'($urandom_range(3)), random_number());
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_number(CMD_S8,  64'd0);
        send_number(CMD_S8,  64'h7F);
        send_number(CMD_S8,  64'h80);
        send_number(CMD_S8,  64'hFFFF_FFFF_FFFF_FFFF);
        send_number(CMD_S8,  64'hA5A5_A5A5_A5A5_A50A);
        send_number(CMD_S16, 64'd0);
        send_number(CMD_S16, 64'h7FFF);
        send_number(CMD_S16, 64'h8000);
        send_number(CMD_S16, 64'hFFFF_FFFF_FFFF_FFFF);
        send_number(CMD_S16, 64'h1234_5678_9ABC_270F);
        send_number(CMD_S64, 64'd0);
        send_number(CMD_S64, 64'h7FFF_FFFF_FFFF_FFFF);
        send_number(CMD_S64, 64'h8000_0000_0000_0000);
        send_number(CMD_S64, 64'hFFFF_FFFF_FFFF_FFFF);
        send_number(CMD_S64, 64'd1000000000000000000);
        send_number(CMD_S64, -64'd10);
        send_number(CMD_U64, 64'd0);
        send_number(CMD_U64, 64'hFFFF_FFFF_FFFF_FFFF);
        send_number(CMD_U64, 64'h8000_0000_0000_0000);
        send_number(CMD_U64, 64'd10000000000000000000);
        send_number(CMD_U64, 64'd9);
        send_number(CMD_U64, 64'd10);
        send_random(100);
        wait_for_drain();

        send_idle_pct = 56;
        recv_idle_pct = 26;
        send_random(100);
        wait_for_drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        holds_requested <= holds_requested + 1;
        send_random(12);
        send_random(98);
        wait_for_drain();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("tb: %0d numbers in all four width modes gave %0d digit transactions,",
                 numbers, digits);
        $display("tb: with idle on both sides, a long output hold and drain pauses");
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/btdd_pkg.sv
rtl/btdd_cell.sv
rtl/binary_to_decimal_digits_core.sv
bench/btdd_digit_checker.sv
bench/binary_to_decimal_digits_core_tb.sv
